// ===== sv/arpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_pkg
// shared types and constants of the arp cache table with aging
// ----------------------------------------------------------------------------
package arpc_pkg;

	localparam int ENTRIES_DEF = 64;

	localparam int OP_W      = 2;
	localparam int IP_W      = 32;
	localparam int MAC_W     = 48;
	localparam int STAMP_W   = 32;
	localparam int SLOT_W    = 6;
	localparam int TIMEOUT_W = 16;

	localparam int S_TDATA_W = 80;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 56;
	localparam int M_TUSER_W = 2;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	typedef logic [OP_W-1:0] op_t;

	localparam op_t OP_LOOKUP = 2'd0;
	localparam op_t OP_INSERT = 2'd1;
	localparam op_t OP_TICK   = 2'd2;

	// word index of the timeout register (paddr bit 2)
	localparam logic [0:0] REG_TIMEOUT = 1'b0;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd15;

	typedef struct packed {
		logic               valid;
		logic [IP_W-1:0]    ip;
		logic [MAC_W-1:0]   mac;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	typedef struct packed {
		logic              found;
		logic [MAC_W-1:0]  mac;
		logic [SLOT_W-1:0] slot;
		logic              full;
	} result_t;

endpackage

// ===== sv/arpc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module arpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/arpc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_ctrl
// table sequencer: clearing pass, per-op scan with read-modify-write
// ----------------------------------------------------------------------------
module arpc_ctrl #(
	parameter int ENTRIES = arpc_pkg::ENTRIES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  arpc_pkg::op_t                    in_op,
	input  logic [arpc_pkg::IP_W-1:0]        in_ip,
	input  logic [arpc_pkg::MAC_W-1:0]       in_mac,
	input  logic [arpc_pkg::TIMEOUT_W-1:0]   timeout,
	output logic                             res_valid,
	input  logic                             res_ready,
	output arpc_pkg::result_t                res
);
	import arpc_pkg::*;

	localparam int ADDR_W = $clog2(ENTRIES);
	localparam logic [ADDR_W-1:0] LAST = ADDR_W'(ENTRIES - 1);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t              state_q;
	logic [ADDR_W-1:0]   rd_addr_q;
	logic                rd_run_q;
	logic                rd_vld_s1;
	logic [ADDR_W-1:0]   rd_addr_s1;
	logic [STAMP_W-1:0]  seconds_q;
	result_t             res_q;

	op_t                 op_q;
	logic [IP_W-1:0]     ip_q;
	logic [MAC_W-1:0]    mac_q;

	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	entry_t              ram_wdata;
	logic                ram_re;
	logic [$bits(entry_t)-1:0] ram_rdata;
	entry_t              rd_entry;

	logic [STAMP_W-1:0]  age;
	logic                hit;
	logic                free_slot;
	logic                expire;
	logic                last_s1;
	logic                accept;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign res_valid = (state_q == ST_FINISH);
	assign res       = res_q;

	assign rd_entry  = entry_t'(ram_rdata);
	assign age       = seconds_q - rd_entry.stamp;
	assign hit       = rd_vld_s1 && rd_entry.valid && (rd_entry.ip == ip_q);
	assign free_slot = rd_vld_s1 && !rd_entry.valid;
	assign expire    = rd_vld_s1 && rd_entry.valid &&
	                   (age > {{(STAMP_W-TIMEOUT_W){1'b0}}, timeout});
	assign last_s1   = (rd_addr_s1 == LAST);
	assign ram_re    = (state_q == ST_SCAN) && rd_run_q;

	// write port: clearing sweep, insert into free slot, or expiry write-back
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = rd_addr_s1;
		ram_wdata = rd_entry;
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = rd_addr_q;
			ram_wdata = '0;
		end else if (state_q == ST_SCAN) begin
			if (op_q == OP_INSERT && free_slot) begin
				ram_we          = 1'b1;
				ram_wdata.valid = 1'b1;
				ram_wdata.ip    = ip_q;
				ram_wdata.mac   = mac_q;
				ram_wdata.stamp = seconds_q;
			end else if (op_q == OP_TICK && expire) begin
				ram_we          = 1'b1;
				ram_wdata.valid = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= in_op;
			ip_q  <= in_ip;
			mac_q <= in_mac;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			rd_addr_q  <= '0;
			rd_run_q   <= 1'b0;
			rd_vld_s1  <= 1'b0;
			rd_addr_s1 <= '0;
			seconds_q  <= '0;
			res_q      <= '0;
		end else begin
			rd_vld_s1  <= ram_re;
			rd_addr_s1 <= rd_addr_q;
			if (ram_re) begin
				rd_addr_q <= rd_addr_q + 1'b1;
				if (rd_addr_q == LAST) begin
					rd_run_q <= 1'b0;
				end
			end
			unique case (state_q)
				ST_CLEAR: begin
					rd_addr_q <= rd_addr_q + 1'b1;
					if (rd_addr_q == LAST) begin
						rd_addr_q <= '0;
						state_q   <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						res_q     <= '0;
						rd_addr_q <= '0;
						unique case (in_op) inside
							OP_LOOKUP, OP_INSERT: begin
								rd_run_q <= 1'b1;
								state_q  <= ST_SCAN;
							end
							OP_TICK: begin
								seconds_q <= seconds_q + 1'b1;
								rd_run_q  <= 1'b1;
								state_q   <= ST_SCAN;
							end
							default: begin
								state_q <= ST_FINISH;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (op_q == OP_LOOKUP && hit) begin
						res_q.found <= 1'b1;
						res_q.mac   <= rd_entry.mac;
						res_q.slot  <= SLOT_W'(rd_addr_s1);
					end
					if (op_q == OP_INSERT && free_slot) begin
						res_q.slot <= SLOT_W'(rd_addr_s1);
						rd_run_q   <= 1'b0;
						rd_vld_s1  <= 1'b0;
						state_q    <= ST_FINISH;
					end else if (rd_vld_s1 && last_s1) begin
						if (op_q == OP_INSERT) begin
							res_q.full <= 1'b1;
						end
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	arpc_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (rd_addr_q),
		.rdata (ram_rdata)
	);

endmodule

// ===== sv/arp_cache_table_with_aging_top.sv =====
`timescale 1ns / 1ps
// operation: lookup, tick and a dropped insert scan every entry before m_tvalid; an insert that
//   finds a free slot stops its scan at that slot; an unused op code skips the scan
// throughput: one item at a time, the next transfer is taken once the result moves into the
//   output register; a scan reads one entry per cycle through the table ram read port
// reset: after arst_n releases, a clearing pass over all ENTRIES slots empties the table,
//   s_tready stays low during it; apb writes are taken at all times
// ----------------------------------------------------------------------------
// arp_cache_table_with_aging_top
// ip-to-mac cache table with lookup, insert and one-second aging tick
// ----------------------------------------------------------------------------
module arp_cache_table_with_aging_top #(
	parameter int ENTRIES = arpc_pkg::ENTRIES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// input stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [arpc_pkg::S_TDATA_W-1:0]     s_tdata,  // ip_addr[31:0], mac_addr[79:32]
	input  logic [arpc_pkg::S_TUSER_W-1:0]     s_tuser,  // operation[1:0]
	// result stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [arpc_pkg::M_TDATA_W-1:0]     m_tdata,  // mac_out[47:0], slot_index[53:48], zero
	output logic [arpc_pkg::M_TUSER_W-1:0]     m_tuser,  // found[0], table_full[1]
	// register port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [arpc_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [arpc_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [arpc_pkg::APB_DATA_W-1:0]    prdata,
	output logic                               pready
);
	import arpc_pkg::*;

	logic [TIMEOUT_W-1:0]  timeout_q;
	logic                  reg_sel;

	logic                  res_valid;
	logic                  res_ready;
	result_t               res;

	logic                  m_tvalid_q;
	logic [M_TDATA_W-1:0]  m_tdata_q;
	logic [M_TUSER_W-1:0]  m_tuser_q;

	// register decode: word index sits above the byte offset
	assign pready  = 1'b1;
	assign reg_sel = (paddr[APB_ADDR_W-1:2] == REG_TIMEOUT);
	assign prdata  = reg_sel ? {{(APB_DATA_W-TIMEOUT_W){1'b0}}, timeout_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			timeout_q <= pwdata[TIMEOUT_W-1:0];
		end
	end

	// sequencer and table memory
	arpc_ctrl #(
		.ENTRIES (ENTRIES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_op     (op_t'(s_tuser[OP_W-1:0])),
		.in_ip     (s_tdata[IP_W-1:0]),
		.in_mac    (s_tdata[IP_W+MAC_W-1:IP_W]),
		.timeout   (timeout_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// output register: frees the sequencer while the result waits downstream
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			m_tdata_q <= {{(M_TDATA_W-MAC_W-SLOT_W){1'b0}}, res.slot, res.mac};
			m_tuser_q <= {res.full, res.found};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// ===== sv/arpc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_checker
// port-level checks of the cache table, bound to the top level
// ----------------------------------------------------------------------------
module arpc_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	input  logic                               s_tready,
	input  logic                               m_tvalid,
	input  logic                               m_tready,
	input  logic [arpc_pkg::M_TDATA_W-1:0]     m_tdata,
	input  logic [arpc_pkg::M_TUSER_W-1:0]     m_tuser
);
	import arpc_pkg::*;

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// a hit is never also a dropped insert
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("found and table_full both set");

	// mac field is zero unless the lookup hit
	a_mac_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> (m_tdata[MAC_W-1:0] == '0))
		else $error("mac_out nonzero without a hit");

	// one item in flight: input closes right after a transfer
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken during a scan");

endmodule

bind arp_cache_table_with_aging_top arpc_checker u_arpc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
